[rtl/core/tksit_pkg.sv]
// Package for the sorted top-k insertion table.
// Holds the field widths, action codes, sequencer states and default depth.
// Used by the top level and the testbench, which take names by scope.
`default_nettype none

package tksit_pkg;

  localparam int unsigned DEFAULT_RANK_DEPTH = 16;

  localparam int unsigned ACTION_W   = 1;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned SCORE_W    = 16;
  localparam int unsigned INDEX_W    = 4;
  localparam int unsigned POSITION_W = 4;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned ENTRY_W    = SCORE_W + TAG_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 1'b0,
    ACT_READ   = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_FINISH,
    ST_READ_RD,
    ST_READ_OUT
  } state_e;

endpackage

`default_nettype wire

[rtl/core/tksit_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
`default_nettype none

module tksit_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/top_k_sorted_insert_table_top.sv]
// Top level of the sorted top-k insertion table.
// Depends on tksit_pkg and on the tksit_ram entry store.
//
// The block keeps up to RANK_DEPTH entries (score and tag) sorted by descending
// score in one RAM. An insert word scans upward from the bottom of the table,
// one entry per step, moving each lower-scoring entry down one place, and then
// writes the new entry in the gap; ties keep arrival order and the last entry
// of a full table falls off. Each step is a RAM read followed by a compare and
// optional write; an insert examines at most the entry count of entries, and
// a read word reads one entry. Both wait in their last state while the output
// is stalled. The block takes one word at a time; it accepts the next word
// while a finished result still waits on the output register. The table
// contents need no clearing after reset.
`default_nettype none

module top_k_sorted_insert_table_top #(
  parameter int unsigned RankDepth = tksit_pkg::DEFAULT_RANK_DEPTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [tksit_pkg::ACTION_W-1:0]      action_i,
  input  wire logic [tksit_pkg::TAG_W-1:0]         player_tag_i,
  input  wire logic [tksit_pkg::SCORE_W-1:0]       score_i,
  input  wire logic [tksit_pkg::INDEX_W-1:0]       read_index_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     inserted_o,
  output logic      [tksit_pkg::POSITION_W-1:0]    insert_position_o,
  output logic      [tksit_pkg::COUNT_W-1:0]       entry_count_o,
  output logic                                     read_valid_o,
  output logic      [tksit_pkg::SCORE_W-1:0]       read_score_o,
  output logic      [tksit_pkg::TAG_W-1:0]         read_tag_o
);

  localparam int unsigned AW = (RankDepth > 1) ? $clog2(RankDepth) : 1;
  localparam int unsigned CW = $clog2(RankDepth + 1);
  localparam int unsigned IW = (CW > tksit_pkg::INDEX_W) ? CW : tksit_pkg::INDEX_W;
  localparam logic [CW-1:0] DepthC = CW'(RankDepth);
  localparam int unsigned SW = tksit_pkg::SCORE_W;
  localparam int unsigned TW = tksit_pkg::TAG_W;
  localparam int unsigned EW = tksit_pkg::ENTRY_W;

  tksit_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] k_q, k_d;
  tksit_pkg::action_e act_q, act_d;
  logic [TW-1:0] tag_q, tag_d;
  logic [SW-1:0] score_q, score_d;
  logic [tksit_pkg::INDEX_W-1:0] ridx_q, ridx_d;

  logic out_valid_q, out_valid_d;
  logic inserted_q, inserted_d;
  logic [tksit_pkg::POSITION_W-1:0] pos_q, pos_d;
  logic [tksit_pkg::COUNT_W-1:0] ecount_q, ecount_d;
  logic rvalid_q, rvalid_d;
  logic [SW-1:0] rscore_q, rscore_d;
  logic [TW-1:0] rtag_q, rtag_d;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [SW-1:0] rd_score;
  logic in_accept, out_free, read_hit;

  tksit_ram #(
    .Width(EW),
    .Depth(RankDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != tksit_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rd_score   = ram_rdata[EW-1:TW];
  assign read_hit   = IW'(ridx_q) < IW'(count_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    act_d       = act_q;
    tag_d       = tag_q;
    score_d     = score_q;
    ridx_d      = ridx_q;
    out_valid_d = out_valid_q && out_stall_i;
    inserted_d  = inserted_q;
    pos_d       = pos_q;
    ecount_d    = ecount_q;
    rvalid_d    = rvalid_q;
    rscore_d    = rscore_q;
    rtag_d      = rtag_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = AW'(k_q);
    ram_wdata   = ram_rdata;
    ram_raddr   = AW'(k_q - CW'(1));

    unique case (state_q)
      tksit_pkg::ST_IDLE: begin
        if (in_accept) begin
          act_d   = tksit_pkg::action_e'(action_i);
          tag_d   = player_tag_i;
          score_d = score_i;
          ridx_d  = read_index_i;
          k_d     = count_q;
          if (tksit_pkg::action_e'(action_i) == tksit_pkg::ACT_READ) begin
            state_d = tksit_pkg::ST_READ_RD;
          end else if (count_q == '0) begin
            state_d = tksit_pkg::ST_FINISH;
          end else begin
            state_d = tksit_pkg::ST_SCAN_RD;
          end
        end
      end
      tksit_pkg::ST_SCAN_RD: begin
        ram_re  = 1'b1;
        state_d = tksit_pkg::ST_SCAN_CMP;
      end
      tksit_pkg::ST_SCAN_CMP: begin
        // A lower score moves down one place; the bottom entry of a full table is lost.
        if (rd_score < score_q) begin
          ram_we = (k_q < DepthC);
          k_d    = k_q - CW'(1);
          if (k_q == CW'(1)) begin
            state_d = tksit_pkg::ST_FINISH;
          end else begin
            state_d = tksit_pkg::ST_SCAN_RD;
          end
        end else begin
          state_d = tksit_pkg::ST_FINISH;
        end
      end
      tksit_pkg::ST_FINISH: begin
        if (out_free) begin
          ram_we      = (k_q < DepthC);
          ram_wdata   = {score_q, tag_q};
          inserted_d  = (k_q < DepthC);
          pos_d       = (k_q < DepthC) ? tksit_pkg::POSITION_W'(k_q) : '0;
          count_d     = (count_q < DepthC) ? count_q + CW'(1) : count_q;
          ecount_d    = tksit_pkg::COUNT_W'(count_d);
          rvalid_d    = 1'b0;
          rscore_d    = '0;
          rtag_d      = '0;
          out_valid_d = 1'b1;
          state_d     = tksit_pkg::ST_IDLE;
        end
      end
      tksit_pkg::ST_READ_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(ridx_q);
        state_d   = tksit_pkg::ST_READ_OUT;
      end
      tksit_pkg::ST_READ_OUT: begin
        if (out_free) begin
          inserted_d  = 1'b0;
          pos_d       = '0;
          ecount_d    = tksit_pkg::COUNT_W'(count_q);
          rvalid_d    = read_hit;
          rscore_d    = read_hit ? ram_rdata[EW-1:TW] : '0;
          rtag_d      = read_hit ? ram_rdata[TW-1:0] : '0;
          out_valid_d = 1'b1;
          state_d     = tksit_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tksit_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tksit_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    act_q      <= act_d;
    tag_q      <= tag_d;
    score_q    <= score_d;
    ridx_q     <= ridx_d;
    inserted_q <= inserted_d;
    pos_q      <= pos_d;
    ecount_q   <= ecount_d;
    rvalid_q   <= rvalid_d;
    rscore_q   <= rscore_d;
    rtag_q     <= rtag_d;
  end

  assign out_valid_o       = out_valid_q;
  assign inserted_o        = inserted_q;
  assign insert_position_o = pos_q;
  assign entry_count_o     = ecount_q;
  assign read_valid_o      = rvalid_q;
  assign read_score_o      = rscore_q;
  assign read_tag_o        = rtag_q;

  // The entry count never exceeds the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DepthC)
    else $error("entry count above table depth");

  // The count only grows, one entry per finished insert until the table is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CW'(1)))
    else $error("entry count changed by more than one");

  // The table is written only while an insert is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (act_q == tksit_pkg::ACT_INSERT && state_q != tksit_pkg::ST_IDLE))
    else $error("table written outside an insert");

  // An insert result never leaves the table empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && inserted_q) |-> (count_q != '0))
    else $error("inserted word with empty table");

endmodule

`default_nettype wire

[test/top_k_sorted_insert_table_top_tb.sv]
// Self-checking testbench for the sorted top-k insertion table.
// Depends on tksit_pkg and top_k_sorted_insert_table_top; predicts each result
// from its own copy of the ranking table and checks every output word.
module top_k_sorted_insert_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RankDepth   = tksit_pkg::DEFAULT_RANK_DEPTH;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned IdlePercent = 9;
  localparam int unsigned RandomWords = 1228;
  localparam int unsigned HoldoffAt   = 300;
  localparam int unsigned HoldoffLen  = 250;
  localparam int unsigned QuietFrom   = 700;
  localparam int unsigned QuietTo     = 900;
  localparam int unsigned DrainAt     = 600;
  localparam int unsigned TailCycles  = 40;

  typedef struct packed {
    tksit_pkg::action_e                action;
    logic [tksit_pkg::TAG_W-1:0]       tag;
    logic [tksit_pkg::SCORE_W-1:0]     score;
    logic [tksit_pkg::INDEX_W-1:0]     index;
    logic                              drain_before;
  } rank_word_t;

  typedef struct packed {
    logic                              inserted;
    logic [tksit_pkg::POSITION_W-1:0]  position;
    logic [tksit_pkg::COUNT_W-1:0]     count;
    logic                              read_valid;
    logic [tksit_pkg::SCORE_W-1:0]     read_score;
    logic [tksit_pkg::TAG_W-1:0]       read_tag;
  } rank_result_t;

  logic                             clk_i        = 1'b0;
  logic                             rst_ni       = 1'b0;
  logic                             in_valid_i   = 1'b0;
  logic                             in_stall_o;
  logic [tksit_pkg::ACTION_W-1:0]   action_i     = tksit_pkg::ACT_INSERT;
  logic [tksit_pkg::TAG_W-1:0]      player_tag_i = '0;
  logic [tksit_pkg::SCORE_W-1:0]    score_i      = '0;
  logic [tksit_pkg::INDEX_W-1:0]    read_index_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i  = 1'b0;
  logic                             inserted_o;
  logic [tksit_pkg::POSITION_W-1:0] insert_position_o;
  logic [tksit_pkg::COUNT_W-1:0]    entry_count_o;
  logic                             read_valid_o;
  logic [tksit_pkg::SCORE_W-1:0]    read_score_o;
  logic [tksit_pkg::TAG_W-1:0]      read_tag_o;

  // Shadow copy of the ranking table.
  logic [tksit_pkg::SCORE_W-1:0] rank_scores [RankDepth];
  logic [tksit_pkg::TAG_W-1:0]   rank_tags   [RankDepth];
  int unsigned                   rank_count = 0;

  rank_word_t   pending_words[$];
  rank_result_t expected_results[$];
  rank_word_t   offered_word;
  int unsigned  words_accepted = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  int unsigned  holdoff_left   = 0;
  logic         holdoff_done   = 1'b0;

  top_k_sorted_insert_table_top #(
    .RankDepth(RankDepth)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .action_i,
    .player_tag_i,
    .score_i,
    .read_index_i,
    .out_valid_o,
    .out_stall_i,
    .inserted_o,
    .insert_position_o,
    .entry_count_o,
    .read_valid_o,
    .read_score_o,
    .read_tag_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one word to the shadow table and returns the result it must produce.
  function automatic rank_result_t apply_rank_word(rank_word_t w);
    rank_result_t r;
    int unsigned  pos;
    int unsigned  k;
    r = '0;
    if (w.action == tksit_pkg::ACT_INSERT) begin
      pos = rank_count;
      // Ties stop the scan, so an equal score lands behind the older entry.
      while (pos > 0 && rank_scores[pos-1] < w.score) pos--;
      if (pos < RankDepth) begin
        k = (rank_count >= RankDepth) ? RankDepth - 1 : rank_count;
        while (k > pos) begin
          rank_scores[k] = rank_scores[k-1];
          rank_tags[k]   = rank_tags[k-1];
          k--;
        end
        rank_scores[pos] = w.score;
        rank_tags[pos]   = w.tag;
        if (rank_count < RankDepth) rank_count++;
        r.inserted = 1'b1;
        r.position = pos[tksit_pkg::POSITION_W-1:0];
      end
    end else if (w.index < rank_count) begin
      r.read_valid = 1'b1;
      r.read_score = rank_scores[w.index];
      r.read_tag   = rank_tags[w.index];
    end
    r.count = rank_count[tksit_pkg::COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic sender_quiet();
    return words_accepted >= QuietFrom && words_accepted < QuietTo;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      action_i       <= tksit_pkg::ACT_INSERT;
      player_tag_i   <= '0;
      score_i        <= '0;
      read_index_i   <= '0;
      words_accepted <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(apply_rank_word(offered_word));
        words_accepted <= words_accepted + 1;
      end
      // A stalled word holds its payload; otherwise the slot is free.
      if (!in_valid_i || !in_stall_o) begin
        if (pending_words.size() != 0 &&
            (!pending_words[0].drain_before ||
             (expected_results.size() == 0 && !in_valid_i)) &&
            (sender_quiet() || $urandom_range(99) >= IdlePercent)) begin
          offered_word = pending_words.pop_front();
          in_valid_i   <= 1'b1;
          action_i     <= offered_word.action;
          player_tag_i <= offered_word.tag;
          score_i      <= offered_word.score;
          read_index_i <= offered_word.index;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off that backs up the input side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall_i  <= 1'b1;
    end else if (!holdoff_done && words_accepted >= HoldoffAt) begin
      holdoff_left <= HoldoffLen;
      holdoff_done <= 1'b1;
      out_stall_i  <= 1'b1;
    end else begin
      out_stall_i <= !sender_quiet() && ($urandom_range(99) < IdlePercent);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatch_count++;
      end else begin
        rank_result_t e;
        e = expected_results.pop_front();
        check_field("inserted", 32'(e.inserted), 32'(inserted_o));
        check_field("insert_position", 32'(e.position), 32'(insert_position_o));
        check_field("entry_count", 32'(e.count), 32'(entry_count_o));
        check_field("read_valid", 32'(e.read_valid), 32'(read_valid_o));
        check_field("read_score", 32'(e.read_score), 32'(read_score_o));
        check_field("read_tag", e.read_tag, read_tag_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_insert(logic [tksit_pkg::TAG_W-1:0] tag,
                              logic [tksit_pkg::SCORE_W-1:0] score, logic drain);
    pending_words.push_back('{tksit_pkg::ACT_INSERT, tag, score,
                              tksit_pkg::INDEX_W'($urandom_range(15)), drain});
  endtask

  task automatic queue_read(logic [tksit_pkg::INDEX_W-1:0] index, logic drain);
    pending_words.push_back('{tksit_pkg::ACT_READ, tksit_pkg::TAG_W'($urandom),
                              tksit_pkg::SCORE_W'($urandom), index, drain});
  endtask

  initial begin
    int unsigned ramp;
    logic [tksit_pkg::SCORE_W-1:0] sc;

    // Reads of an empty table, then fill it with ties at the top score.
    queue_read(tksit_pkg::INDEX_W'(0), 1'b0);
    queue_read(tksit_pkg::INDEX_W'(15), 1'b0);
    queue_insert(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    queue_insert(32'h0, 16'h0, 1'b0);
    queue_insert(32'h1, 16'hFFFF, 1'b0);
    for (int i = 0; i < 13; i++) begin
      queue_insert(32'h100 + i, 16'((i % 7) * 9000), 1'b0);
    end
    // Full table with a zero at the bottom: a zero score is dropped, one enters.
    queue_insert(32'hDEAD_0000, 16'h0, 1'b0);
    queue_insert(32'hDEAD_0001, 16'h1, 1'b0);
    queue_read(tksit_pkg::INDEX_W'(15), 1'b0);
    queue_read(tksit_pkg::INDEX_W'(0), 1'b0);
    queue_read(tksit_pkg::INDEX_W'(7), 1'b0);

    for (int n = 0; n < RandomWords; n++) begin
      if ($urandom_range(99) < 40) begin
        queue_read(tksit_pkg::INDEX_W'($urandom_range(15)), n == 0 || n == DrainAt);
      end else begin
        // A rising band keeps new scores competitive with a full table.
        ramp = n * 52 + $urandom_range(255);
        case ($urandom_range(3))
          0: sc = tksit_pkg::SCORE_W'($urandom);
          1: sc = tksit_pkg::SCORE_W'($urandom_range(1) ? 16'hFFFF - $urandom_range(3)
                                                         : $urandom_range(3));
          default: sc = (ramp > 65535) ? 16'hFFFF : tksit_pkg::SCORE_W'(ramp);
        endcase
        queue_insert(tksit_pkg::TAG_W'($urandom), sc, n == 0 || n == DrainAt);
      end
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/tksit_pkg.sv
rtl/core/tksit_ram.sv
rtl/core/top_k_sorted_insert_table_top.sv
test/top_k_sorted_insert_table_top_tb.sv
